// ===== sv/ptrr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrr_pkg
// Shared types and codes of the pending table with round-robin replay.
// ----------------------------------------------------------------------------
package ptrr_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_NEXT   = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] handle;
        logic [15:0] orig_width;
        logic [15:0] orig_height;
        logic [15:0] scaled_width;
        logic [15:0] scaled_height;
    } entry_t;

    typedef struct packed {
        logic capture;  // item accepted: latch the select bit
        logic live;     // cell index below the entry count
        logic use_rr;   // select by position instead of by tag
        logic rr_hit;   // cell index equals the round-robin position
        logic load;     // write the appended entry
        logic shift;    // take the neighbor's entry
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

// ===== sv/ptrr_if.sv =====
// ----------------------------------------------------------------------------
// ptrr_req_if / ptrr_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ptrr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] tag;
    logic [31:0] handle;
    logic [15:0] orig_width;
    logic [15:0] orig_height;
    logic [15:0] scaled_width;
    logic [15:0] scaled_height;

    modport source (
        output valid, cmd, tag, handle, orig_width, orig_height,
               scaled_width, scaled_height,
        input  ready
    );
    modport sink (
        input  valid, cmd, tag, handle, orig_width, orig_height,
               scaled_width, scaled_height,
        output ready
    );
endinterface

interface ptrr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_tag;
    logic [31:0] out_handle;
    logic [15:0] out_orig_width;
    logic [15:0] out_orig_height;
    logic [15:0] out_scaled_width;
    logic [15:0] out_scaled_height;
    logic [4:0]  occupancy;
    logic        is_full;
    logic        is_empty;

    modport source (
        output valid, status, out_tag, out_handle, out_orig_width, out_orig_height,
               out_scaled_width, out_scaled_height, occupancy, is_full, is_empty,
        input  ready
    );
    modport sink (
        input  valid, status, out_tag, out_handle, out_orig_width, out_orig_height,
               out_scaled_width, out_scaled_height, occupancy, is_full, is_empty,
        output ready
    );
endinterface

// ===== sv/ptrr_cell.sv =====
// ----------------------------------------------------------------------------
// ptrr_cell
// One table slot: holds an entry, compares its tag, shifts from its neighbor.
// ----------------------------------------------------------------------------
module ptrr_cell
    import ptrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  logic [31:0] cmp_tag,
    input  entry_t      load_data,
    input  entry_t      next_data,
    output entry_t      data,
    output logic        sel
);

    entry_t data_reg;
    entry_t data_next;
    logic   sel_reg;
    logic   sel_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = next_data;
        end
    end

    always_comb
    begin
        sel_next = sel_reg;
        if (ctrl.capture)
        begin
            sel_next = ctrl.live & (ctrl.use_rr ? ctrl.rr_hit : (data_reg.tag == cmp_tag));
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

    assign data = data_reg;
    assign sel  = sel_reg;

endmodule

// ===== sv/pending_table_round_robin_replay_top.sv =====
// ----------------------------------------------------------------------------
// pending_table_round_robin_replay_top
// Pending table in insertion order with add, remove, round-robin next, lookup.
// ----------------------------------------------------------------------------
// Per item, in the accept cycle every cell compares its tag with the item's
// tag (or marks the round-robin slot for next) and registers a select bit; in
// the execute state the selected entry is read out through an AND-OR across
// the row, the count and position are updated, and the cells load or shift.
// A new item is taken only after the last one executes; the result register
// lets the next item enter while an earlier result still waits. The user must
// write capacity through cfg_we/cfg_wdata only while the block is idle; the
// block does not enforce it. Capacity resets to 10. Table entries have no
// reset; only slots below the count ever take part in a compare.
// ----------------------------------------------------------------------------
module pending_table_round_robin_replay_top
    import ptrr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    ptrr_req_if.sink           req,
    ptrr_rsp_if.source         rsp
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int POS_W = IDX_W + 1;

    typedef struct packed {
        logic [2:0]       status;
        entry_t           entry;
        logic [OCC_W-1:0] occupancy;
        logic             is_full;
        logic             is_empty;
    } result_t;

    // Control and bookkeeping
    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   rr_reg, rr_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic [1:0]         cmd_reg;
    entry_t             item_reg;

    logic               accept;
    logic               exec_fire;

    // Cell row
    cell_ctrl_t         ctrl   [DEPTH];
    entry_t             cdata  [DEPTH];
    logic [DEPTH-1:0]   sel_vec;

    entry_t             pick;
    logic [IDX_W-1:0]   pick_idx;
    logic               hit;
    logic               full_now;
    logic               add_ok;
    logic               rm_ok;

    function automatic logic full_of(input logic [CNT_W-1:0] cnt,
                                     input logic [CAP_W-1:0] cap);
        return (CMP_W'(cnt) >= CMP_W'(cap)) || (CNT_W'(DEPTH) <= cnt);
    endfunction

    assign accept    = req.valid & req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign exec_fire = (state_reg == S_EXEC) & (~out_valid_reg | rsp.ready);

    // Gather the selected entry; tags are unique, so at most one bit is set
    always_comb
    begin
        pick     = '0;
        pick_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel_vec[i])
            begin
                pick     = pick | cdata[i];
                pick_idx = pick_idx | IDX_W'(i);
            end
        end
    end

    assign hit      = |sel_vec;
    assign full_now = full_of(count_reg, cap_reg);
    assign add_ok   = (cmd_reg == CMD_ADD) & ~full_now & ~hit;
    assign rm_ok    = (cmd_reg == CMD_REMOVE) & hit;

    // Build the cells and their control
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            ctrl[i].capture = accept;
            ctrl[i].live    = CNT_W'(i) < count_reg;
            ctrl[i].use_rr  = (req.cmd == CMD_NEXT);
            ctrl[i].rr_hit  = (IDX_W'(i) == rr_reg);
            ctrl[i].load    = exec_fire & add_ok & (count_reg[IDX_W-1:0] == IDX_W'(i));
            ctrl[i].shift   = exec_fire & rm_ok & (IDX_W'(i) >= pick_idx);
        end

        ptrr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[i]),
            .cmp_tag   (req.tag),
            .load_data (item_reg),
            .next_data ((i == DEPTH - 1) ? cdata[i] : cdata[(i + 1) % DEPTH]),
            .data      (cdata[i]),
            .sel       (sel_vec[i])
        );
    end

    // Execute the held item: status, count, position and the result
    always_comb
    begin
        logic [IDX_W-1:0] rr_adj;
        logic [POS_W-1:0] pos_inc;
        logic [2:0]       status;
        entry_t           ent;

        count_next = count_reg;
        rr_next    = rr_reg;
        status     = ST_OK;
        ent        = '0;
        rr_adj     = rr_reg;
        pos_inc    = POS_W'(rr_reg) + POS_W'(1);

        case (cmd_reg)
            CMD_ADD:
            begin
                if (full_now)
                begin
                    status = ST_FULL;
                end
                else if (hit)
                begin
                    status = ST_DUP;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (!hit)
                begin
                    status = ST_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (pick_idx < rr_reg)
                    begin
                        rr_adj = rr_reg - IDX_W'(1);
                    end
                    rr_next = (CNT_W'(rr_adj) >= count_next) ? '0 : rr_adj;
                end
            end
            CMD_NEXT:
            begin
                // The position always stays below a nonzero count
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    ent     = pick;
                    rr_next = (pos_inc >= POS_W'(count_reg)) ? '0 : rr_reg + IDX_W'(1);
                end
            end
            CMD_LOOKUP:
            begin
                if (hit)
                begin
                    ent = pick;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        out_next           = out_reg;
        if (exec_fire)
        begin
            out_next.status    = status;
            out_next.entry     = ent;
            out_next.occupancy = OCC_W'(count_next);
            out_next.is_full   = full_of(count_next, cap_reg);
            out_next.is_empty  = (count_next == '0);
        end
        if (!exec_fire)
        begin
            count_next = count_reg;
            rr_next    = rr_reg;
        end
    end

    // Sequence: accept, then execute once the result register is free
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cap_next = cfg_we ? cfg_wdata : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_W'(10);
            count_reg     <= '0;
            rr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            rr_reg        <= rr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the accepted item and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg                <= req.cmd;
            item_reg.tag           <= req.tag;
            item_reg.handle        <= req.handle;
            item_reg.orig_width    <= req.orig_width;
            item_reg.orig_height   <= req.orig_height;
            item_reg.scaled_width  <= req.scaled_width;
            item_reg.scaled_height <= req.scaled_height;
        end
        out_reg <= out_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_reg.status;
    assign rsp.out_tag           = out_reg.entry.tag;
    assign rsp.out_handle        = out_reg.entry.handle;
    assign rsp.out_orig_width    = out_reg.entry.orig_width;
    assign rsp.out_orig_height   = out_reg.entry.orig_height;
    assign rsp.out_scaled_width  = out_reg.entry.scaled_width;
    assign rsp.out_scaled_height = out_reg.entry.scaled_height;
    assign rsp.occupancy         = out_reg.occupancy;
    assign rsp.is_full           = out_reg.is_full;
    assign rsp.is_empty          = out_reg.is_empty;

    // Tags in live slots are unique, so no more than one cell is selected
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(sel_vec))
        else $error("more than one cell selected");

    // The position stays inside the occupied slots
    a_rr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) ? (rr_reg == '0) : (CNT_W'(rr_reg) < count_reg))
        else $error("round-robin position outside table");

    // The count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A refused or missed operation leaves the count as it was
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && !add_ok && !rm_ok) |=> (count_reg == $past(count_reg)))
        else $error("count changed without add or remove");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Tests the pending table with round-robin replay against a shadow table.
// ----------------------------------------------------------------------------
// A short table of directed commands exercises the empty, full, duplicate
// and extreme-value cases. Random commands then run over a series of
// capacity settings. Every accepted command is pushed through a shadow copy
// of the table; its predicted result, or an explicit row's own, is queued. Each
// accepted result item is compared field by field with the oldest queued result.
// The sender works in random bursts, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
    import ptrr_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int TIMEOUT_CYCLES  = 500000;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int NUM_PHASES      = 10;
    localparam int TAG_POOL_SIZE   = 48;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 8;

    // Directed rows either carry an explicit result or defer to the shadow table.
    localparam bit EXPLICIT  = 1'b1;
    localparam bit PREDICTED = 1'b0;
    // An explicit result either echoes the row's own entry fields or has none.
    localparam bit ECHO      = 1'b1;
    localparam bit NO_ENTRY  = 1'b0;

    typedef enum int {SINK_FREE, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

    typedef struct packed {
        logic [1:0] cmd;
        entry_t     e;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0] status;
        entry_t     e;
        logic [4:0] occupancy;
        logic       is_full;
        logic       is_empty;
    } reply_t;

    typedef struct packed {
        cmd_item_t  item;
        bit         typed;
        logic [2:0] w_status;
        bit         w_echo;
        logic [4:0] w_occ;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    ptrr_req_if req_ch ();
    ptrr_rsp_if rsp_ch ();

    pending_table_round_robin_replay_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shadow table: the predicted contents, count, position and capacity.
    // ------------------------------------------------------------------
    entry_t         shadow_entries [DEPTH];
    int             shadow_count;
    int             shadow_rr;
    logic [CAP_W-1:0] shadow_cap;
    int             peak_occupancy;

    reply_t         pending_replies [$];
    step_row_t      steps [$];
    logic [31:0]    tag_pool [TAG_POOL_SIZE];

    int             fail_count = 0;
    int             results_seen = 0;
    int             cmd_count [4];
    int             status_count [8] = '{default: 0};
    int             capacities_run;

    sink_mode_t     sink_mode;
    bit             hold_off_req;

    // Free-running clock.
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard limit on the run, well above the slowest correct run.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

    function automatic int find_slot(logic [31:0] tag);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_entries[i].tag == tag)
                return i;
        end
        return -1;
    endfunction

    // Full at capacity, and also whenever every cell is taken.
    function automatic bit shadow_full();
        return (shadow_count >= int'(shadow_cap)) || (shadow_count >= DEPTH);
    endfunction

    // Apply one command to the shadow table and return the result it causes.
    function automatic reply_t predict_reply(cmd_item_t it);
        reply_t r;
        int     slot;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_ADD:
            begin
                // Full check comes ahead of the duplicate check.
                if (shadow_full())
                    r.status = ST_FULL;
                else if (find_slot(it.e.tag) >= 0)
                    r.status = ST_DUP;
                else
                begin
                    shadow_entries[shadow_count] = it.e;
                    shadow_count++;
                end
            end
            CMD_REMOVE:
            begin
                slot = find_slot(it.e.tag);
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // Close the gap; keep the position on the same entry.
                    for (int i = slot; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                    if (slot < shadow_rr)
                        shadow_rr--;
                    if (shadow_rr >= shadow_count)
                        shadow_rr = 0;
                end
            end
            CMD_NEXT:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (shadow_rr >= shadow_count)
                        shadow_rr = 0;
                    r.e = shadow_entries[shadow_rr];
                    shadow_rr++;
                    if (shadow_rr >= shadow_count)
                        shadow_rr = 0;
                end
            end
            default:
            begin
                slot = find_slot(it.e.tag);
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r.e = shadow_entries[slot];
            end
        endcase
        r.occupancy = 5'(shadow_count);
        r.is_full   = shadow_full();
        r.is_empty  = (shadow_count == 0);
        if (shadow_count > peak_occupancy)
            peak_occupancy = shadow_count;
        return r;
    endfunction

    // Mostly well-formed traffic: adds draw from a small tag pool so that
    // duplicates happen, removes and lookups mostly hit live entries, and a
    // slice of the items is pure noise with fully random tags.
    function automatic cmd_item_t random_cmd(int add_pct);
        cmd_item_t it;
        int        roll;
        it.e.tag           = $urandom();
        it.e.handle        = $urandom();
        it.e.orig_width    = 16'($urandom());
        it.e.orig_height   = 16'($urandom());
        it.e.scaled_width  = 16'($urandom());
        it.e.scaled_height = 16'($urandom());
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            it.cmd = 2'($urandom_range(0, 3));
            return it;
        end
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
        begin
            it.cmd   = CMD_ADD;
            it.e.tag = tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)];
            return it;
        end
        roll = $urandom_range(0, 99);
        if (roll < 35)
            it.cmd = CMD_NEXT;
        else if (roll < 70)
            it.cmd = CMD_REMOVE;
        else
            it.cmd = CMD_LOOKUP;
        if (it.cmd != CMD_NEXT)
        begin
            if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                it.e.tag = shadow_entries[$urandom_range(0, shadow_count - 1)].tag;
            else
                it.e.tag = tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)];
        end
        return it;
    endfunction

    function automatic step_row_t row(logic [1:0] cmd, logic [31:0] tag, logic [31:0] handle,
                                      logic [63:0] dims, bit typed, logic [2:0] st,
                                      bit echo, logic [4:0] occ);
        step_row_t s;
        s.item.cmd = cmd;
        s.item.e   = {tag, handle, dims};
        s.typed    = typed;
        s.w_status = st;
        s.w_echo   = echo;
        s.w_occ    = occ;
        return s;
    endfunction

    // Append one row to the end of the directed table.
    function automatic void add_step(step_row_t s);
        steps.insert(steps.size(), s);
    endfunction

    // Offer one item and hold it until the block takes it. Enter and leave
    // on a falling edge; queue the expected result at the accepting edge.
    task automatic send_cmd(input cmd_item_t it, input bit typed, input reply_t typed_want);
        reply_t predicted;
        req_ch.valid         = 1'b1;
        req_ch.cmd           = it.cmd;
        req_ch.tag           = it.e.tag;
        req_ch.handle        = it.e.handle;
        req_ch.orig_width    = it.e.orig_width;
        req_ch.orig_height   = it.e.orig_height;
        req_ch.scaled_width  = it.e.scaled_width;
        req_ch.scaled_height = it.e.scaled_height;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_reply(it);
        pending_replies.insert(pending_replies.size(), typed ? typed_want : predicted);
        cmd_count[it.cmd]++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_results();
        req_ch.valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write capacity only while idle; the extra cycles cover the accept and
    // execute states in case anything is still in flight.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_wdata = cap;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we     = 1'b0;
        shadow_cap = cap;
        capacities_run++;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern chosen per phase. A hold-off request
    // from the sender side blocks results for a long stretch, counted here.
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        int          hold_left;
        bit          hold_done;
        logic [15:0] stall_bits;
        hold_left    = 0;
        hold_done    = 1'b0;
        stall_bits   = 16'b1101_1011_0111_0110;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_FREE:    rsp_ch.ready = 1'b1;
                    SINK_PATTERN: rsp_ch.ready = stall_bits[0];
                    default:      rsp_ch.ready = ($urandom_range(0, 2) != 0);
                endcase
                stall_bits = {stall_bits[0], stall_bits[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result item with the oldest
    // queued prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        reply_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("result item with no command outstanding, status %0h", rsp_ch.status);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                status_count[want.status]++;
                check_field("status",            32'(want.status),     32'(rsp_ch.status));
                check_field("out_tag",           want.e.tag,           rsp_ch.out_tag);
                check_field("out_handle",        want.e.handle,        rsp_ch.out_handle);
                check_field("out_orig_width",    32'(want.e.orig_width),
                            32'(rsp_ch.out_orig_width));
                check_field("out_orig_height",   32'(want.e.orig_height),
                            32'(rsp_ch.out_orig_height));
                check_field("out_scaled_width",  32'(want.e.scaled_width),
                            32'(rsp_ch.out_scaled_width));
                check_field("out_scaled_height", 32'(want.e.scaled_height),
                            32'(rsp_ch.out_scaled_height));
                check_field("occupancy",         32'(want.occupancy),  32'(rsp_ch.occupancy));
                check_field("is_full",           32'(want.is_full),    32'(rsp_ch.is_full));
                check_field("is_empty",          32'(want.is_empty),   32'(rsp_ch.is_empty));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random phases over several capacities.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        reply_t           typed_want;
        logic [CAP_W-1:0] phase_cap [NUM_PHASES];
        int               phase_add [NUM_PHASES];
        int               phase_gap [NUM_PHASES];
        sink_mode_t       phase_sink [NUM_PHASES];
        int               burst_left;
        int               gap;

        // Drive every input to a known value while reset is held low.
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_ADD;
        req_ch.tag           = '0;
        req_ch.handle        = '0;
        req_ch.orig_width    = '0;
        req_ch.orig_height   = '0;
        req_ch.scaled_width  = '0;
        req_ch.scaled_height = '0;
        sink_mode            = SINK_PATTERN;
        hold_off_req         = 1'b0;
        capacities_run       = 0;
        peak_occupancy       = 0;
        cmd_count            = '{default: 0};
        shadow_count         = 0;
        shadow_rr            = 0;
        shadow_cap           = 5'd10;

        tag_pool[0] = 32'h0000_0000;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < TAG_POOL_SIZE; i++)
            tag_pool[i] = $urandom();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, capacity still at its reset value of ten.
        // Empty table: next flags empty, remove and lookup miss.
        add_step(row(CMD_NEXT,   32'h0, 32'h0, 64'h0, EXPLICIT, ST_EMPTY, NO_ENTRY, 5'd0));
        add_step(row(CMD_REMOVE, 32'h0, 32'h0, 64'h0,
                     EXPLICIT, ST_NOT_FOUND, NO_ENTRY, 5'd0));
        add_step(row(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 64'h0,
                     EXPLICIT, ST_NOT_FOUND, NO_ENTRY, 5'd0));
        // All-zero and all-one entries, then a duplicate of the zero tag.
        add_step(row(CMD_ADD, 32'h0, 32'h0, 64'h0, EXPLICIT, ST_OK, NO_ENTRY, 5'd1));
        add_step(row(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     EXPLICIT, ST_OK, NO_ENTRY, 5'd2));
        add_step(row(CMD_ADD, 32'h0, 32'h1234_5678, 64'h1,
                     EXPLICIT, ST_DUP, NO_ENTRY, 5'd2));
        // Lookups of the extremes return the stored entry unchanged.
        add_step(row(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     EXPLICIT, ST_OK, ECHO, 5'd2));
        add_step(row(CMD_LOOKUP, 32'h0, 32'h0, 64'h0, EXPLICIT, ST_OK, ECHO, 5'd2));
        // Round robin, remove before the position, remove at the position.
        add_step(row(CMD_ADD, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 64'h1234_5678_9ABC_DEF0,
                     PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_ADD, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 64'h0001_8000_7FFF_FFFE,
                     PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_NEXT,   32'h0, 32'h0, 64'h0, PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_NEXT,   32'h0, 32'h0, 64'h0, PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_REMOVE, 32'h0, 32'h0, 64'h0, PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_NEXT,   32'h0, 32'h0, 64'h0, PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_REMOVE, 32'h0F0F_0F0F, 32'h0, 64'h0,
                     PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_NEXT,   32'h0, 32'h0, 64'h0, PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        // Fill to capacity, then one fresh add and one duplicate add while full.
        for (int i = 0; i < 9; i++)
            add_step(row(CMD_ADD, 32'h100 + i, $urandom(), {$urandom(), $urandom()},
                         PREDICTED, ST_OK, NO_ENTRY, 5'd0));
        add_step(row(CMD_ADD, 32'hFFFF_FFFF, 32'h0, 64'h0,
                     PREDICTED, ST_OK, NO_ENTRY, 5'd0));

        foreach (steps[i])
        begin
            typed_want           = '0;
            typed_want.status    = steps[i].w_status;
            typed_want.e         = steps[i].w_echo ? steps[i].item.e : '0;
            typed_want.occupancy = steps[i].w_occ;
            typed_want.is_full   = 1'b0;
            typed_want.is_empty  = (steps[i].w_occ == 0);
            send_cmd(steps[i].item, steps[i].typed, typed_want);
        end

        // Random phases: capacity, add bias, sender gap bound, receiver mode.
        // Capacity zero refuses every add; capacity above the depth stops at
        // the depth. Low add bias drains the table toward empty.
        phase_cap  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd10, 5'd13, 5'd16, 5'd7, 5'd1};
        phase_add  = '{55, 35, 30, 60, 40, 15, 50, 45, 25, 40};
        phase_gap  = '{0, 6, 3, 4, 8, 2, 0, 5, 3, 1};
        phase_sink = '{SINK_FREE, SINK_PATTERN, SINK_RANDOM, SINK_PATTERN, SINK_RANDOM,
                       SINK_PATTERN, SINK_RANDOM, SINK_FREE, SINK_RANDOM, SINK_PATTERN};

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_capacity(phase_cap[p]);
            sink_mode  = phase_sink[p];
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Start a new burst after a random gap with valid low.
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap = $urandom_range(0, phase_gap[p]);
                    if (gap > 0)
                    begin
                        req_ch.valid = 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                burst_left--;
                // Block the results for a long stretch while items keep coming,
                // so the block backs up and stalls its input.
                if (p == 0 && n == 30)
                    hold_off_req = 1'b1;
                // Pause the sender until every result is back.
                if (p == 2 && n == 50)
                    drain_results();
                send_cmd(random_cmd(phase_add[p]), PREDICTED, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("ran %0d commands: %0d add, %0d remove, %0d next, %0d lookup; %0d capacities",
                 cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3], cmd_count[CMD_ADD],
                 cmd_count[CMD_REMOVE], cmd_count[CMD_NEXT], cmd_count[CMD_LOOKUP],
                 capacities_run);
        $display("results %0d: ok %0d, miss %0d, full %0d, dup %0d, empty %0d; peak occupancy %0d",
                 results_seen, status_count[ST_OK], status_count[ST_NOT_FOUND],
                 status_count[ST_FULL], status_count[ST_DUP], status_count[ST_EMPTY],
                 peak_occupancy);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
